FILE: rtl/wehist_pkg.sv
// Shared types and constants for the waveform envelope history block.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package wehist_pkg;

    // Input opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_LAST   = 2'd1;
    localparam logic [1:0] OP_EMPTY  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // Configuration register indexes
    localparam logic REG_ALPHA     = 1'b0;
    localparam logic REG_DEAD_ZONE = 1'b1;

    localparam logic [15:0] ALPHA_RESET     = 16'd6554;
    localparam logic [14:0] DEAD_ZONE_RESET = 15'd328;

    // Stored value of a zero envelope
    localparam logic [15:0] SILENCE = 16'h8000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Command from front to back: an envelope update with its peak,
    // or a history read with the slot in the low 9 bits.
    typedef struct packed {
        logic        is_read;
        logic [15:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: rtl/wehist_front.sv
// Front end: averages each stereo pair to mono, tracks the update peak and
// issues update and read commands. Depends on wehist_pkg.
`timescale 1ns / 1ps

module wehist_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          opcode,
    input  logic signed [15:0]  left_sample,
    input  logic signed [15:0]  right_sample,
    input  logic [8:0]          read_slot,
    output logic                push,
    output wehist_pkg::cmd_t    push_cmd
);

    logic signed [16:0] pair_sum;
    logic signed [15:0] mono;
    logic        [15:0] mono_mag;
    logic               new_peak;
    logic        [15:0] peak_mag_reg;
    logic signed [15:0] peak_val_reg;

    // Arithmetic shift of the sum floors toward minus infinity
    assign pair_sum = 17'(left_sample) + 17'(right_sample);
    assign mono     = pair_sum[16:1];
    assign mono_mag = mono[15] ? 16'(-mono) : mono;
    assign new_peak = mono_mag > peak_mag_reg;

    assign push = accept && (opcode != wehist_pkg::OP_SAMPLE);

    always_comb
    begin
        push_cmd = '0;
        unique case (opcode)
            wehist_pkg::OP_SAMPLE:
            begin
                push_cmd = '0;
            end
            wehist_pkg::OP_LAST:
            begin
                push_cmd.is_read = 1'b0;
                push_cmd.data    = new_peak ? mono : peak_val_reg;
            end
            wehist_pkg::OP_EMPTY:
            begin
                push_cmd.is_read = 1'b0;
                push_cmd.data    = '0;
            end
            wehist_pkg::OP_READ:
            begin
                push_cmd.is_read = 1'b1;
                push_cmd.data    = {7'd0, read_slot};
            end
            default:
            begin
                push_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_mag_reg <= '0;
            peak_val_reg <= '0;
        end
        else if (accept)
        begin
            unique case (opcode) inside
                wehist_pkg::OP_SAMPLE:
                begin
                    if (new_peak)
                    begin
                        peak_mag_reg <= mono_mag;
                        peak_val_reg <= mono;
                    end
                end
                wehist_pkg::OP_LAST, wehist_pkg::OP_EMPTY:
                begin
                    peak_mag_reg <= '0;
                    peak_val_reg <= '0;
                end
                wehist_pkg::OP_READ:
                begin
                    // hold the peak gathered so far
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/wehist_fifo.sv
// Short command queue between the front end and the back end.
// Depends on wehist_pkg for the command type and depth.
`timescale 1ns / 1ps

module wehist_fifo
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  wehist_pkg::cmd_t         push_cmd,
    input  logic                     pop,
    output wehist_pkg::cmd_t         head_cmd,
    output wehist_pkg::fifo_status_t status
);

    wehist_pkg::cmd_t entries_reg [wehist_pkg::QUEUE_DEPTH];

    logic [wehist_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [wehist_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [wehist_pkg::QUEUE_AW:0]   count_reg;

    assign head_cmd     = entries_reg[rd_ptr_reg];
    assign status.full  = count_reg == (wehist_pkg::QUEUE_AW + 1)'(wehist_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/wehist_back.sv
// Back end: envelope update with one multiply, dead-zone snap, ring history
// memory, history reads and the output register. Depends on wehist_pkg.
`timescale 1ns / 1ps

module wehist_back
#(
    parameter int HISTORY_DEPTH = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  wehist_pkg::cmd_t    head_cmd,
    output logic                pop,
    input  logic [15:0]         alpha,
    input  logic [14:0]         dead_zone,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         history_value,
    output logic [8:0]          slot,
    output logic                was_read
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = ((AW > 9) ? AW : 9) + 1;

    logic [15:0] mem [HISTORY_DEPTH];

    logic               s1_valid_reg;
    logic               s1_is_read_reg;
    logic [8:0]         s1_rs_reg;
    logic               s1_hit_reg;
    logic signed [33:0] prod_reg;
    logic [15:0]        rd_reg;

    logic signed [15:0] env_reg;
    logic signed [15:0] env_next;
    logic [AW-1:0]      wptr_reg;
    logic [AW-1:0]      wptr_next;
    logic               wrapped_reg;

    logic               out_valid_reg;
    logic [15:0]        value_reg;
    logic [8:0]         slot_reg;
    logic               was_read_reg;

    logic               out_free;
    logic               s1_done;
    logic               commit;
    logic [CW-1:0]      rs_ext;
    logic [CW-1:0]      wptr_ext;
    logic               hit;
    logic [AW-1:0]      rd_addr;
    logic signed [16:0] diff;
    logic signed [17:0] delta;
    logic signed [18:0] env_sum;
    logic signed [15:0] env_clamped;
    logic        [15:0] env_mag;
    logic        [15:0] stored;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_done  = s1_valid_reg && out_free;
    assign commit   = s1_done && !s1_is_read_reg;

    // An update in flight owns the envelope and the memory until it commits
    assign pop = head_valid && (!s1_valid_reg || (s1_done && s1_is_read_reg));

    // Slots below the fill count have been written; the rest read as silence
    assign rs_ext   = CW'(head_cmd.data[8:0]);
    assign wptr_ext = CW'(wptr_reg);
    assign hit      = (rs_ext < CW'(HISTORY_DEPTH)) && (wrapped_reg || (rs_ext < wptr_ext));
    assign rd_addr  = rs_ext[AW-1:0];

    assign diff = 17'($signed(head_cmd.data)) - 17'(env_reg);

    assign delta   = prod_reg[33:16];
    assign env_sum = 19'(env_reg) + 19'(delta);

    always_comb
    begin
        if (env_sum > 19'sd32767)
        begin
            env_clamped = 16'sd32767;
        end
        else if (env_sum < -19'sd32768)
        begin
            env_clamped = -16'sd32768;
        end
        else
        begin
            env_clamped = env_sum[15:0];
        end
    end

    assign env_mag  = env_clamped[15] ? 16'(-env_clamped) : env_clamped;
    assign env_next = (env_mag < {1'b0, dead_zone}) ? 16'sd0 : env_clamped;
    assign stored   = {~env_next[15], env_next[14:0]};

    assign wptr_next = (wptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;

    // History memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            mem[wptr_reg] <= stored;
        end
        if (pop && head_cmd.is_read)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_is_read_reg <= head_cmd.is_read;
            s1_rs_reg      <= head_cmd.data[8:0];
            s1_hit_reg     <= hit;
            prod_reg       <= $signed({18'd0, alpha}) * 34'(diff);
        end
        if (s1_done)
        begin
            if (s1_is_read_reg)
            begin
                value_reg    <= s1_hit_reg ? rd_reg : wehist_pkg::SILENCE;
                slot_reg     <= s1_rs_reg;
                was_read_reg <= 1'b1;
            end
            else
            begin
                value_reg    <= stored;
                slot_reg     <= wptr_ext[8:0];
                was_read_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            env_reg       <= '0;
            wptr_reg      <= '0;
            wrapped_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                env_reg  <= env_next;
                wptr_reg <= wptr_next;
                if (wptr_reg == AW'(HISTORY_DEPTH - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign history_value = value_reg;
    assign slot          = slot_reg;
    assign was_read      = was_read_reg;

endmodule

FILE: rtl/waveform_envelope_history.sv
// Top level of the waveform envelope history block: configuration registers,
// front end, command queue and back end. Depends on wehist_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_stall) takes one stereo pair per transaction
//   with an opcode: sample, last sample of an update, empty update, or read.
//   Output channel (out_valid/out_stall) carries one result per update or
//   read; plain samples produce none.
//   Configuration channel (cfg_valid/cfg_ready) writes alpha (index 0) or the
//   dead zone (index 1); it is always ready and should be used while idle.
// Path: an accepted transaction is written into the queue, moves into the
//   back-end stage register and then into the output register.
// Throughput: one input transaction per cycle while in_stall is low. A read
//   leaves the back end as the next command enters; an update holds it off
//   until it commits, as the envelope recurrence runs through the multiplier;
//   a 4-entry queue absorbs bursts; in_stall rises only while it is full.
// Reset clears the peak, envelope, write slot and fill count; unwritten
//   history slots read as 32768, so no clearing pass is run.
// When out_stall is high, the result is held and the back end waits;
//   the front keeps accepting until the queue fills.

module waveform_envelope_history
#(
    parameter int HISTORY_DEPTH = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic [8:0]         read_slot,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        history_value,
    output logic [8:0]         slot,
    output logic               was_read,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0] alpha_reg;
    logic [14:0] dead_zone_reg;

    logic                     in_accept;
    logic                     fifo_push;
    logic                     fifo_pop;
    wehist_pkg::cmd_t         push_cmd;
    wehist_pkg::cmd_t         head_cmd;
    wehist_pkg::fifo_status_t fifo_stat;

    assign cfg_ready = 1'b1;
    assign in_stall  = fifo_stat.full;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= wehist_pkg::ALPHA_RESET;
            dead_zone_reg <= wehist_pkg::DEAD_ZONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wehist_pkg::REG_ALPHA:     alpha_reg     <= cfg_data;
                wehist_pkg::REG_DEAD_ZONE: dead_zone_reg <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    wehist_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .opcode       (opcode),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .read_slot    (read_slot),
        .push         (fifo_push),
        .push_cmd     (push_cmd)
    );

    wehist_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .head_cmd (head_cmd),
        .status   (fifo_stat)
    );

    wehist_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!fifo_stat.empty),
        .head_cmd      (head_cmd),
        .pop           (fifo_pop),
        .alpha         (alpha_reg),
        .dead_zone     (dead_zone_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .history_value (history_value),
        .slot          (slot),
        .was_read      (was_read)
    );

    // The front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) fifo_push |-> !fifo_stat.full)
        else $error("command pushed into full queue");

    // The back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) fifo_pop |-> !fifo_stat.empty)
        else $error("command popped from empty queue");

    // A read beyond the history returns silence
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_read && ({23'd0, slot} >= HISTORY_DEPTH))
        |-> (history_value == wehist_pkg::SILENCE))
        else $error("out-of-range read returned stored data");

endmodule

FILE: dv/tb_waveform_envelope_history.sv
// Self-checking testbench for waveform_envelope_history: drives stereo sample
// transactions and register writes, predicts envelope updates and history reads.
// Depends on rtl/wehist_pkg.sv and rtl/waveform_envelope_history.sv.
`timescale 1ns / 1ps

module tb_waveform_envelope_history;

    localparam int HIST_DEPTH     = 512;
    localparam int PHASE_ITEMS    = 260;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int DRAIN_LIMIT    = 20000;

    typedef struct packed {
        logic [15:0] value;
        logic [8:0]  slot;
        logic        was_read;
    } result_t;

    // Tracks peak, envelope and history ring; queues the results each
    // accepted transaction must produce.
    class envelope_checker;
        int          alpha;
        int          dead_zone;
        int          peak_mag;
        int          peak_val;
        int          env;
        int unsigned wr_slot;
        logic [15:0] history_mem [HIST_DEPTH];
        result_t     due_results [$];
        int          errors;
        int          n_updates;
        int          n_reads;

        function new();
            alpha     = int'(wehist_pkg::ALPHA_RESET);
            dead_zone = int'(wehist_pkg::DEAD_ZONE_RESET);
            peak_mag  = 0;
            peak_val  = 0;
            env       = 0;
            wr_slot   = 0;
            errors    = 0;
            n_updates = 0;
            n_reads   = 0;
            foreach (history_mem[i])
                history_mem[i] = wehist_pkg::SILENCE;
        endfunction

        function void set_reg(logic idx, logic [15:0] data);
            if (idx == wehist_pkg::REG_ALPHA)
                alpha = int'(data);
            else
                dead_zone = int'(data[14:0]);
        endfunction

        // Average to mono (floor) and keep the first value of largest magnitude.
        function void fold_pair(logic signed [15:0] l, logic signed [15:0] r);
            int mono;
            int mag;
            mono = (int'(l) + int'(r)) >>> 1;
            mag  = (mono < 0) ? -mono : mono;
            if (mag > peak_mag)
            begin
                peak_mag = mag;
                peak_val = mono;
            end
        endfunction

        function void close_update(int peak);
            longint  prod;
            longint  next_env;
            result_t r;
            prod     = longint'(alpha) * longint'(peak - env);
            next_env = longint'(env) + (prod >>> 16);
            if (next_env > 32767)
                next_env = 32767;
            if (next_env < -32768)
                next_env = -32768;
            env = int'(next_env);
            if (((env < 0) ? -env : env) < dead_zone)
                env = 0;
            r.value    = 16'(env + 32768);
            r.slot     = 9'(wr_slot);
            r.was_read = 1'b0;
            history_mem[wr_slot] = r.value;
            wr_slot  = (wr_slot + 1) % HIST_DEPTH;
            peak_mag = 0;
            peak_val = 0;
            due_results.push_back(r);
            n_updates++;
        endfunction

        function void note_input(logic [1:0] op, logic signed [15:0] l,
                                 logic signed [15:0] r, logic [8:0] rs);
            result_t res;
            case (op)
                wehist_pkg::OP_SAMPLE: fold_pair(l, r);
                wehist_pkg::OP_LAST:
                begin
                    fold_pair(l, r);
                    close_update(peak_val);
                end
                wehist_pkg::OP_EMPTY: close_update(0);
                default:
                begin
                    res.value    = (int'(rs) < HIST_DEPTH) ? history_mem[rs]
                                                           : wehist_pkg::SILENCE;
                    res.slot     = rs;
                    res.was_read = 1'b1;
                    due_results.push_back(res);
                    n_reads++;
                end
            endcase
        endfunction

        function void check_output(logic [15:0] value, logic [8:0] sl, logic rd);
            result_t exp_r;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: history_value %0d, slot %0d, was_read %0d",
                       value, sl, rd);
                errors++;
                return;
            end
            exp_r = due_results.pop_front();
            if (value !== exp_r.value)
            begin
                $error("history_value: expected %0d, actual %0d", exp_r.value, value);
                errors++;
            end
            if (sl !== exp_r.slot)
            begin
                $error("slot: expected %0d, actual %0d", exp_r.slot, sl);
                errors++;
            end
            if (rd !== exp_r.was_read)
            begin
                $error("was_read: expected %0d, actual %0d", exp_r.was_read, rd);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [8:0]         read_slot;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        history_value;
    logic [8:0]         slot;
    logic               was_read;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [15:0]        cfg_data;

    envelope_checker checker_h;
    int              burst_left;
    bit              gaps_on;
    bit              hold_req;
    int              items_sent;
    int              reg_writes;
    int              long_holds;

    waveform_envelope_history #(.HISTORY_DEPTH(HIST_DEPTH)) uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .read_slot     (read_slot),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .history_value (history_value),
        .slot          (slot),
        .was_read      (was_read),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Transaction monitors: values read here are the ones held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            checker_h.note_input(opcode, left_sample, right_sample, read_slot);
        if (rst_n && out_valid && !out_stall)
            checker_h.check_output(history_value, slot, was_read);
    end

    // Output stall pattern: one of four random modes (none, light, heavy or periodic), long hold on request.
    initial
    begin
        int cnt;
        int mode;
        out_stall <= 1'b0;
        cnt  = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                long_holds++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (cnt % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (cnt % 5 < 2);
                endcase
                cnt++;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] l,
                             input logic [15:0] r, input logic [8:0] rs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        opcode       <= op;
        left_sample  <= l;
        right_sample <= r;
        read_slot    <= rs;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic wait_idle();
        int waited;
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (checker_h.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (checker_h.pending() != 0)
        begin
            $error("%0d results never arrived", checker_h.pending());
            checker_h.errors++;
            checker_h.due_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        checker_h.set_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample(int scale);
        case (scale)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1200) - 600);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0000;
                    default: return 16'h0001;
                endcase
            end
            default: return 16'($urandom_range(0, 16000) - 8000);
        endcase
    endfunction

    function automatic logic [8:0] pick_slot();
        if ($urandom_range(0, 1) == 0)
            return 9'($urandom_range(0, HIST_DEPTH - 1));
        return 9'(checker_h.wr_slot - 1 - $urandom_range(0, 7));
    endfunction

    task automatic run_phase();
        int phase_items;
        int n_samples;
        int scale;
        int pick;
        bit held;
        bit paused;
        phase_items = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (phase_items < PHASE_ITEMS)
        begin
            // Mostly well-formed updates: a few samples, then the closing pair.
            n_samples = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 16)
                                                     : $urandom_range(0, 2);
            scale = $urandom_range(0, 3);
            for (int k = 0; k < n_samples; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(wehist_pkg::OP_READ, pick_sample(0), pick_sample(0),
                              pick_slot());
                else
                    send_item(wehist_pkg::OP_SAMPLE, pick_sample(scale),
                              pick_sample(scale), 9'($urandom));
                phase_items++;
            end
            pick = $urandom_range(0, 29);
            if (pick < 3)
                send_item(wehist_pkg::OP_EMPTY, pick_sample(0), pick_sample(0),
                          9'($urandom));
            else if (pick == 3)
                send_item(wehist_pkg::OP_READ, pick_sample(0), pick_sample(0),
                          pick_slot());
            else
                send_item(wehist_pkg::OP_LAST, pick_sample(scale), pick_sample(scale),
                          9'($urandom));
            phase_items++;
            if (!held && phase_items >= 80)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && phase_items >= 170)
            begin
                wait_idle();
                paused = 1'b1;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        logic [15:0] alpha_set [7];
        logic [15:0] dz_set    [7];
        checker_h  = new();
        burst_left = 0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        items_sent = 0;
        reg_writes = 0;
        long_holds = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= wehist_pkg::OP_SAMPLE;
        left_sample  <= '0;
        right_sample <= '0;
        read_slot    <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= wehist_pkg::REG_ALPHA;
        cfg_data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset settings.
        send_item(wehist_pkg::OP_READ,   16'h0000, 16'h0000, 9'd0);
        send_item(wehist_pkg::OP_READ,   16'hFFFF, 16'hFFFF, 9'd511);
        send_item(wehist_pkg::OP_EMPTY,  16'h7FFF, 16'h8000, 9'h0AA);
        send_item(wehist_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF, 9'h155);
        send_item(wehist_pkg::OP_SAMPLE, 16'h8000, 16'h8000, 9'd0);
        send_item(wehist_pkg::OP_LAST,   16'h0000, 16'h0000, 9'd0);
        // Equal magnitudes: the first one seen wins.
        send_item(wehist_pkg::OP_SAMPLE, 16'd100,  16'd100,  9'd0);
        send_item(wehist_pkg::OP_SAMPLE, -16'sd100, -16'sd100, 9'd0);
        send_item(wehist_pkg::OP_LAST,   16'hFFFF, 16'h0000, 9'd0);
        send_item(wehist_pkg::OP_SAMPLE, 16'h7FFF, 16'h8000, 9'd0);
        send_item(wehist_pkg::OP_SAMPLE, -16'sd3,  16'h0000, 9'd0);
        send_item(wehist_pkg::OP_READ,   16'h0000, 16'h0000, 9'd0);
        send_item(wehist_pkg::OP_LAST,   16'd5,    16'd4,    9'd0);
        // Empty update throws away the peak gathered so far.
        send_item(wehist_pkg::OP_SAMPLE, 16'd20000, 16'd20000, 9'd0);
        send_item(wehist_pkg::OP_EMPTY,  16'h0000, 16'h0000, 9'd0);
        // A read in the middle of an update leaves the peak alone.
        send_item(wehist_pkg::OP_SAMPLE, 16'd12000, -16'sd2000, 9'd0);
        send_item(wehist_pkg::OP_READ,   16'h0000, 16'h0000, 9'd1);
        send_item(wehist_pkg::OP_LAST,   16'h0000, 16'h0000, 9'd0);
        send_item(wehist_pkg::OP_READ,   16'h0000, 16'h0000, 9'd2);
        send_item(wehist_pkg::OP_READ,   16'h0000, 16'h0000, 9'd3);
        send_item(wehist_pkg::OP_READ,   16'h0000, 16'h0000, 9'd4);
        send_item(wehist_pkg::OP_LAST,   16'h8000, 16'h8000, 9'd0);
        send_item(wehist_pkg::OP_LAST,   16'h7FFF, 16'h7FFF, 9'd0);
        send_item(wehist_pkg::OP_READ,   16'h0000, 16'h0000, 9'h155);
        wait_idle();

        alpha_set = '{16'hFFFF, 16'd0, 16'd40000, 16'd1, 16'h8000,
                      wehist_pkg::ALPHA_RESET, 16'($urandom)};
        dz_set    = '{16'd0, 16'd0, 16'd32767, 16'd0, 16'd100,
                      16'(wehist_pkg::DEAD_ZONE_RESET), 16'($urandom_range(0, 2000))};
        for (int p = 0; p < 7; p++)
        begin
            write_reg(wehist_pkg::REG_ALPHA, alpha_set[p]);
            write_reg(wehist_pkg::REG_DEAD_ZONE, dz_set[p]);
            gaps_on = (p != 1);
            run_phase();
        end

        $display("Covered %0d transactions: %0d envelope updates, %0d history reads,",
                 items_sent, checker_h.n_updates, checker_h.n_reads);
        $display("%0d register writes, %0d long output holds.", reg_writes, long_holds);
        if (checker_h.errors == 0 && checker_h.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
